### hw/rtl/e2c_pkg.sv
// Shared types, constants and month table for the epoch-to-calendar converter.
package e2c_pkg;

	localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [31:0] DAYS_PER_GRP  = 32'd1461;
	localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
	localparam logic [31:0] SECS_PER_MIN  = 32'd60;
	localparam logic [11:0] BASE_YEAR     = 12'd1970;
	localparam logic [5:0]  LAST_MONTH    = 6'd47;

	// Reciprocals for exact division over each stage's input range
	localparam logic [25:0] DAY_RECIP  = 26'd50903317; // 2^35 / 675, rounded up
	localparam logic [16:0] GRP_RECIP  = 17'd91868;    // 2^27 / 1461, rounded up
	localparam logic [13:0] HOUR_RECIP = 14'd9321;     // 2^21 / 225, rounded up
	localparam logic [10:0] MIN_RECIP  = 11'd1093;     // 2^14 / 15, rounded up

	// Month lengths over one four-year group, leap February in the third year
	localparam logic [4:0] MONTH_LEN [0:47] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [31:0] second_fraction;
	} in_item_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  whole_second;
		logic [31:0] fraction_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_GRP,
		ST_HOUR,
		ST_MIN,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_DAY,
		PH_GRP,
		PH_HOUR,
		PH_MIN
	} div_phase_t;

	typedef struct packed {
		logic       load;
		logic       step;
		div_phase_t phase;
		logic       walk;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/epoch_seconds_to_calendar.sv
// Top level of the epoch-seconds to calendar date and time converter.
// Usage:
//   Input channel in_valid/in_ready/in_data carries whole seconds since
//   1970-01-01 00:00:00 and a 0.32 fixed-point fraction. Output channel
//   out_valid/out_ready/out_data carries year, month, day, hour, minute,
//   whole second and the unchanged fraction. Seconds past the end of 2099
//   clamp to 2099-12-31 23:59:59.
//   An accepted item passes through four reciprocal-multiply stages (days,
//   four-year group, hour, minute) and then the month walk (one month per
//   cycle), which steps over k whole months (0..47) within the four-year
//   group before the result goes to the output register. One item is in
//   flight at a time.
//   A finished item waits in the output register; a new item is accepted
//   meanwhile, and its result is held back only if the register is still
//   full when it completes.
//   Reset (arst_n low) returns the controller to idle and empties the
//   output register.
module epoch_seconds_to_calendar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  e2c_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output e2c_pkg::out_item_t out_data
);
	import e2c_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	e2c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	e2c_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hw/rtl/e2c_ctrl.sv
// Controller state machine sequencing the division stages, month walk and result hand-off.
module e2c_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  e2c_pkg::dp_stat_t stat,
	output e2c_pkg::dp_cmd_t  cmd
);
	import e2c_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold the current step of the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance through the division stages, then wait on the month walk and the output register
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DAY;
			end
			ST_DAY: begin
				state_nxt = ST_GRP;
			end
			ST_GRP: begin
				state_nxt = ST_HOUR;
			end
			ST_HOUR: begin
				state_nxt = ST_MIN;
			end
			ST_MIN: begin
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		cmd       = '0;
		cmd.phase = PH_DAY;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DAY: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_DAY;
			end
			ST_GRP: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_GRP;
			end
			ST_HOUR: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_HOUR;
			end
			ST_MIN: begin
				cmd.step  = 1'b1;
				cmd.phase = PH_MIN;
			end
			ST_WALK: begin
				cmd.walk = !stat.walk_done;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hw/rtl/e2c_dpath.sv
// Datapath: reciprocal-multiply division stages, month walk and output register.
module e2c_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  e2c_pkg::in_item_t  in_data,
	input  e2c_pkg::dp_cmd_t   cmd,
	output e2c_pkg::dp_stat_t  stat,
	output logic               out_valid,
	input  logic               out_ready,
	output e2c_pkg::out_item_t out_data
);
	import e2c_pkg::*;

	logic [31:0] secs_q;
	logic [15:0] days_q;
	logic [16:0] tod_q;
	logic [5:0]  grp_q;
	logic [10:0] day_q;
	logic [4:0]  hour_q;
	logic [11:0] min_secs_q;
	logic [5:0]  minute_q;
	logic [5:0]  sec_q;
	logic [5:0]  mon_q;
	logic [31:0] frac_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [31:0] sat_secs;
	logic [50:0] day_prod;
	logic [15:0] day_quo;
	logic [31:0] tod_n;
	logic [32:0] grp_prod;
	logic [5:0]  grp_quo;
	logic [31:0] day_n;
	logic [26:0] hour_prod;
	logic [4:0]  hour_quo;
	logic [31:0] min_n;
	logic [20:0] min_prod;
	logic [5:0]  min_quo;
	logic [31:0] sec_n;
	logic [4:0]  cur_len;
	logic [1:0]  year_ofs;
	logic [5:0]  mon_in_year;
	out_item_t   result;

	// Clamp to the last second of 2099
	assign sat_secs = (in_data.epoch_seconds > LAST_SECOND) ? LAST_SECOND
		: in_data.epoch_seconds;

	// Split into days and time of day: s / 86400 = (s >> 7) / 675
	assign day_prod = {26'b0, secs_q[31:7]} * {25'b0, DAY_RECIP};
	assign day_quo  = day_prod[50:35];
	assign tod_n    = secs_q - {16'b0, day_quo} * SECS_PER_DAY;

	// Split days into four-year group and day within the group
	assign grp_prod = {17'b0, days_q} * {16'b0, GRP_RECIP};
	assign grp_quo  = grp_prod[32:27];
	assign day_n    = {16'b0, days_q} - {26'b0, grp_quo} * DAYS_PER_GRP;

	// Take the hour: t / 3600 = (t >> 4) / 225
	assign hour_prod = {14'b0, tod_q[16:4]} * {13'b0, HOUR_RECIP};
	assign hour_quo  = hour_prod[25:21];
	assign min_n     = {15'b0, tod_q} - {27'b0, hour_quo} * SECS_PER_HOUR;

	// Take the minute: r / 60 = (r >> 2) / 15
	assign min_prod = {11'b0, min_secs_q[11:2]} * {10'b0, MIN_RECIP};
	assign min_quo  = min_prod[19:14];
	assign sec_n    = {20'b0, min_secs_q} - {26'b0, min_quo} * SECS_PER_MIN;

	assign cur_len = MONTH_LEN[mon_q];

	// Split the month index into year within the group and month of year
	always_comb begin
		if (mon_q >= 6'd36) begin
			year_ofs = 2'd3;
		end else if (mon_q >= 6'd24) begin
			year_ofs = 2'd2;
		end else if (mon_q >= 6'd12) begin
			year_ofs = 2'd1;
		end else begin
			year_ofs = 2'd0;
		end
		mon_in_year = mon_q - 6'(year_ofs) * 6'd12;
	end

	always_comb begin
		result.year         = BASE_YEAR + {4'b0, grp_q, 2'b00} + {10'b0, year_ofs};
		result.month        = mon_in_year[3:0] + 4'd1;
		result.day_of_month = day_q[4:0] + 5'd1;
		result.hour         = hour_q;
		result.minute       = minute_q;
		result.whole_second = sec_q;
		result.fraction_out = frac_q;
	end

	assign stat.walk_done = ({6'b0, day_q} < {12'b0, cur_len}) || (mon_q == LAST_MONTH);
	assign stat.out_free  = !out_valid_q || out_ready;

	// Stage and field registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			secs_q <= sat_secs;
			frac_q <= in_data.second_fraction;
		end else if (cmd.step) begin
			case (cmd.phase)
				PH_DAY: begin
					days_q <= day_quo;
					tod_q  <= tod_n[16:0];
				end
				PH_GRP: begin
					grp_q <= grp_quo;
					day_q <= day_n[10:0];
				end
				PH_HOUR: begin
					hour_q     <= hour_quo;
					min_secs_q <= min_n[11:0];
				end
				PH_MIN: begin
					minute_q <= min_quo;
					sec_q    <= sec_n[5:0];
					mon_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.walk) begin
			day_q <= day_q - {6'b0, cur_len};
			mon_q <= mon_q + 6'd1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/e2c_chk.sv
// Port-level checker for the converter, bound to the top level.
module e2c_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input e2c_pkg::out_item_t out_data
);
	import e2c_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Only one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// Year within the supported span
	a_year: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.year >= 12'd1970 && out_data.year <= 12'd2099)
		else $error("year out of range");

	// Month in range and day of month at least one
	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.month >= 4'd1 && out_data.month <= 4'd12
			&& out_data.day_of_month >= 5'd1)
		else $error("date out of range");

	// Time of day in range
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hour <= 5'd23 && out_data.minute <= 6'd59
			&& out_data.whole_second <= 6'd59)
		else $error("time of day out of range");

endmodule

bind epoch_seconds_to_calendar e2c_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### verif/e2c_checker.sv
`timescale 1ns / 100ps
// Watches both item channels, predicts each calendar result and compares it with the block's.
module e2c_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  e2c_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  e2c_pkg::out_item_t out_data,
	output int                 mismatch_count,
	output int                 outstanding
);
	import e2c_pkg::*;

	localparam logic [31:0] CLAMP_SECONDS = 32'd4102444799;
	localparam int unsigned DAY_SECONDS   = 86400;
	localparam int unsigned HOUR_SECONDS  = 3600;
	localparam int unsigned GROUP_DAYS    = 1461;
	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned GROUP_MONTHS  = 48;

	out_item_t calendar_queue [$];

	// Length of a month counted from January of the first year of a four-year group
	function automatic int unsigned month_length(int unsigned idx);
		int unsigned m;
		m = idx % 12;
		if (m == 1)
			return (idx == 25) ? 29 : 28;
		if (m == 3 || m == 5 || m == 8 || m == 10)
			return 30;
		return 31;
	endfunction

	// Break saturated epoch seconds into date and time of day
	function automatic out_item_t civil_time_of(in_item_t it);
		int unsigned secs, days, tod, grp, doy, mon, len;
		out_item_t r;
		secs = (it.epoch_seconds > CLAMP_SECONDS) ? CLAMP_SECONDS : it.epoch_seconds;
		days = secs / DAY_SECONDS;
		tod  = secs % DAY_SECONDS;
		grp  = days / GROUP_DAYS;
		doy  = days % GROUP_DAYS;
		// walk whole months within the group
		mon = 0;
		len = month_length(0);
		while (mon < GROUP_MONTHS - 1 && doy >= len) begin
			doy = doy - len;
			mon = mon + 1;
			len = month_length(mon);
		end
		r.year         = 12'(EPOCH_YEAR + grp * 4 + mon / 12);
		r.month        = 4'(mon % 12 + 1);
		r.day_of_month = 5'(doy + 1);
		r.hour         = 5'(tod / HOUR_SECONDS);
		r.minute       = 6'((tod % HOUR_SECONDS) / 60);
		r.whole_second = 6'(tod % 60);
		r.fraction_out = it.second_fraction;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
		mismatch_count = mismatch_count + 1;
	endtask

	// Predict on each accepted input item, compare on each accepted result
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				calendar_queue.push_back(civil_time_of(in_data));
			if (out_valid && out_ready) begin
				if (calendar_queue.size() == 0) begin
					report_mismatch("unexpected result, year", 32'(out_data.year), 32'd0);
				end else begin
					want = calendar_queue.pop_front();
					if (out_data.year !== want.year)
						report_mismatch("year", 32'(out_data.year), 32'(want.year));
					if (out_data.month !== want.month)
						report_mismatch("month", 32'(out_data.month), 32'(want.month));
					if (out_data.day_of_month !== want.day_of_month)
						report_mismatch("day", 32'(out_data.day_of_month), 32'(want.day_of_month));
					if (out_data.hour !== want.hour)
						report_mismatch("hour", 32'(out_data.hour), 32'(want.hour));
					if (out_data.minute !== want.minute)
						report_mismatch("minute", 32'(out_data.minute), 32'(want.minute));
					if (out_data.whole_second !== want.whole_second)
						report_mismatch("second", 32'(out_data.whole_second),
							32'(want.whole_second));
					if (out_data.fraction_out !== want.fraction_out)
						report_mismatch("fraction", out_data.fraction_out, want.fraction_out);
				end
			end
			outstanding <= calendar_queue.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the epoch-to-calendar testbench: clock, reset, stimulus, result pacing and verdict.
module tb_top;
	import e2c_pkg::*;

	localparam int unsigned LAST_DAY     = 47481;
	localparam int unsigned PHASE_ITEMS  = 300;
	localparam int unsigned SETTLE_CYCLES = 120;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int mismatch_count;
	int outstanding;
	int send_idle = 23;
	int recv_idle = 78;

	epoch_seconds_to_calendar DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	e2c_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_timestamp(logic [31:0] secs, logic [31:0] frac);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{epoch_seconds: secs, second_fraction: frac};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Hold the input idle until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Mostly in-range times, with day edges, clamped values and raw words mixed in
	task automatic send_random_timestamp();
		int unsigned pick, day;
		logic [31:0] secs, frac;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			secs = $urandom_range(0, LAST_SECOND);
		end else if (pick < 80) begin
			day = $urandom_range(0, LAST_DAY);
			case ($urandom_range(0, 2))
				0:       secs = day * 86400;
				1:       secs = day * 86400 + 86399;
				default: secs = day * 86400 + $urandom_range(0, 86399);
			endcase
		end else if (pick < 90) begin
			secs = $urandom_range(LAST_SECOND + 1, 32'hFFFF_FFFF);
		end else begin
			secs = $urandom;
		end
		case ($urandom_range(0, 9))
			0:       frac = '0;
			1:       frac = '1;
			default: frac = $urandom;
		endcase
		send_timestamp(secs, frac);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: epoch start, month and year edges, leap days, clamp edge
		send_timestamp(32'd0, 32'h0000_0000);
		send_timestamp(32'd0, 32'hFFFF_FFFF);
		send_timestamp(32'd45296, $urandom);
		send_timestamp(32'd86399, $urandom);
		send_timestamp(32'd86400, $urandom);
		send_timestamp(32'd2678399, $urandom);
		send_timestamp(32'd2678400, $urandom);
		send_timestamp(32'd31535999, $urandom);
		send_timestamp(32'd31536000, $urandom);
		send_timestamp(32'd68169599, $urandom);
		send_timestamp(32'd68169600, $urandom);
		send_timestamp(32'd68255999, $urandom);
		send_timestamp(32'd68256000, $urandom);
		send_timestamp(32'd94607999, $urandom);
		send_timestamp(32'd126230399, $urandom);
		send_timestamp(32'd126230400, $urandom);
		send_timestamp(32'd951825600, $urandom);
		send_timestamp(32'd2147483647, $urandom);
		send_timestamp(32'd2147483648, $urandom);
		send_timestamp(32'd4102358400, $urandom);
		send_timestamp(LAST_SECOND, 32'hFFFF_FFFF);
		send_timestamp(LAST_SECOND + 32'd1, 32'h0000_0000);
		send_timestamp(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();

		// Random: eager sender with stalling receiver, then the reverse, then full rate
		repeat (PHASE_ITEMS) send_random_timestamp();
		drain_results();
		send_idle = 78;
		recv_idle = 23;
		repeat (PHASE_ITEMS) send_random_timestamp();
		drain_results();
		send_idle = 0;
		recv_idle = 0;
		repeat (PHASE_ITEMS) send_random_timestamp();
		drain_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
